### sv/xmov_pkg.sv
// ----------------------------------------------------------------------------
// xmov_pkg
// Shared types, opcode constants and field helpers for the MOV byte decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xmov_pkg;

    typedef enum logic [1:0] {
        KIND_RM_REG  = 2'd0,
        KIND_IMM_RM  = 2'd1,
        KIND_IMM_REG = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    localparam logic [7:0] OP_RM_REG   = 8'b1000_1000;
    localparam logic [7:0] OP_IMM_RM   = 8'b1100_0110;
    localparam logic [7:0] OP_IMM_REG  = 8'b1011_0000;
    localparam logic [7:0] MASK_RM_REG = 8'b1111_1100;
    localparam logic [7:0] MASK_IMM_RM = 8'b1111_1110;
    localparam logic [7:0] MASK_IMM_RG = 8'b1111_0000;

    localparam logic [1:0] MOD_MEM     = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [2:0] RM_DIRECT   = 3'd6;

    typedef struct packed {
        kind_t       kind;
        logic        direction;
        logic        wide;
        logic [1:0]  mode_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
    } result_t;

    function automatic kind_t classify(input logic [7:0] b);
        kind_t k;
        if ((b & MASK_RM_REG) == OP_RM_REG) begin
            k = KIND_RM_REG;
        end
        else if ((b & MASK_IMM_RM) == OP_IMM_RM) begin
            k = KIND_IMM_RM;
        end
        else if ((b & MASK_IMM_RG) == OP_IMM_REG) begin
            k = KIND_IMM_REG;
        end
        else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            MOD_DISP8:  n = 2'd1;
            MOD_DISP16: n = 2'd2;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/xmov_decode.sv
// ----------------------------------------------------------------------------
// xmov_decode
// Instruction position tracking and field capture; flags a finished
// instruction and presents its decoded fields in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmov_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       code_byte,
    output logic                  done,
    output xmov_pkg::result_t     result
);
    import xmov_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [2:0]  exp_len_reg, exp_len_next;

    kind_t       first_kind;
    kind_t       cur_kind;
    logic [1:0]  new_disp_n;
    logic [1:0]  old_disp_n;
    logic [2:0]  idx;
    logic [2:0]  pos_inc;
    logic        hi_sel;

    assign first_kind = classify(code_byte);
    assign cur_kind   = classify(opcode_reg);
    assign new_disp_n = disp_bytes(code_byte);
    assign old_disp_n = disp_bytes(modrm_reg);
    assign idx        = pos_reg - 3'd2;
    assign pos_inc    = pos_reg + 3'd1;
    assign hi_sel     = (idx < {1'b0, old_disp_n}) ? idx[0] : (idx[0] ^ old_disp_n[0]);

    always_comb
    begin
        pos_next     = pos_reg;
        opcode_next  = opcode_reg;
        modrm_next   = modrm_reg;
        disp_next    = disp_reg;
        imm_next     = imm_reg;
        exp_len_next = exp_len_reg;
        done         = 1'b0;
        result       = '0;

        if (accept) begin
            if (pos_reg == 3'd0) begin
                opcode_next = code_byte;
                modrm_next  = '0;
                disp_next   = '0;
                imm_next    = '0;
                if (first_kind == KIND_UNKNOWN) begin
                    exp_len_next  = 3'd1;
                    done          = 1'b1;
                    result.kind   = KIND_UNKNOWN;
                    result.length = 3'd1;
                end
                else begin
                    exp_len_next = (first_kind == KIND_IMM_REG) ?
                                   3'd2 + {2'b00, code_byte[3]} : 3'd2;
                    pos_next     = 3'd1;
                end
            end
            else begin
                if (cur_kind == KIND_IMM_REG) begin
                    if (pos_reg == 3'd1) begin
                        imm_next = {8'h00, code_byte};
                    end
                    else begin
                        imm_next = {code_byte, imm_reg[7:0]};
                    end
                end
                else if (pos_reg == 3'd1) begin
                    modrm_next   = code_byte;
                    exp_len_next = 3'd2 + {1'b0, new_disp_n};
                    if (cur_kind == KIND_IMM_RM) begin
                        exp_len_next = exp_len_next + 3'd1 + {2'b00, opcode_reg[0]};
                    end
                end
                else if (idx < {1'b0, old_disp_n}) begin
                    if (hi_sel) begin
                        disp_next = {code_byte, disp_reg[7:0]};
                    end
                    else begin
                        disp_next = {disp_reg[15:8], code_byte};
                    end
                end
                else begin
                    if (hi_sel) begin
                        imm_next = {code_byte, imm_reg[7:0]};
                    end
                    else begin
                        imm_next = {imm_reg[15:8], code_byte};
                    end
                end

                pos_next = pos_inc;
                if (pos_inc >= exp_len_next) begin
                    pos_next         = 3'd0;
                    done             = 1'b1;
                    result.kind      = cur_kind;
                    result.immediate = imm_next;
                    result.length    = exp_len_next;
                    unique case (cur_kind)
                        KIND_IMM_REG:
                        begin
                            result.wide      = opcode_reg[3];
                            result.reg_field = opcode_reg[2:0];
                        end
                        KIND_RM_REG, KIND_IMM_RM:
                        begin
                            result.direction    = (cur_kind == KIND_RM_REG) ? opcode_reg[1] : 1'b0;
                            result.wide         = opcode_reg[0];
                            result.mode_field   = modrm_next[7:6];
                            result.reg_field    = modrm_next[5:3];
                            result.rm_field     = modrm_next[2:0];
                            result.displacement = disp_next;
                        end
                        default:
                        begin
                            result.length = 3'd1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= '0;
            opcode_reg  <= '0;
            modrm_reg   <= '0;
            disp_reg    <= '0;
            imm_reg     <= '0;
            exp_len_reg <= '0;
        end
        else begin
            pos_reg     <= pos_next;
            opcode_reg  <= opcode_next;
            modrm_reg   <= modrm_next;
            disp_reg    <= disp_next;
            imm_reg     <= imm_next;
            exp_len_reg <= exp_len_next;
        end
    end

endmodule

`default_nettype wire

### sv/xmov_out_stage.sv
// ----------------------------------------------------------------------------
// xmov_out_stage
// Result register toward the output channel; takes a new beat whenever
// the held one is empty or leaving.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmov_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire xmov_pkg::result_t result_in,
    output logic                  can_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output xmov_pkg::result_t     result_out
);
    import xmov_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_take   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take) begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the beat leaves
    always_ff @(posedge clk)
    begin
        if (can_take && load) begin
            res_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

### sv/x86_mov_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// x86_mov_byte_stream_decoder
// Byte-serial decoder for the three 8086 MOV forms plus unknown opcodes.
// ----------------------------------------------------------------------------
// Result: valid in the cycle after the last byte of an instruction is accepted.
// Throughput: one code byte per cycle; the single result register sets it,
// stalling input only while a result waits for out_ready.
// Reset: asynchronous; clears the byte position (expecting an opcode),
// all captured fields and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module x86_mov_byte_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  code_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic             direction,
    output logic             wide,
    output logic [1:0]       mode_field,
    output logic [2:0]       reg_field,
    output logic [2:0]       rm_field,
    output logic [15:0]      displacement,
    output logic [15:0]      immediate,
    output logic [2:0]       length
);
    import xmov_pkg::*;

    logic    accept;
    logic    done;
    result_t dec_res;
    result_t out_res;

    assign accept = in_valid && in_ready;

    xmov_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_byte (code_byte),
        .done      (done),
        .result    (dec_res)
    );

    xmov_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (done),
        .result_in  (dec_res),
        .can_take   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_res)
    );

    assign kind         = out_res.kind;
    assign direction    = out_res.direction;
    assign wide         = out_res.wide;
    assign mode_field   = out_res.mode_field;
    assign reg_field    = out_res.reg_field;
    assign rm_field     = out_res.rm_field;
    assign displacement = out_res.displacement;
    assign immediate    = out_res.immediate;
    assign length       = out_res.length;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length >= 3'd1 && length <= 3'd6))
        else $error("result length out of range");

    a_unknown_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_UNKNOWN) |-> (length == 3'd1 && immediate == 16'h0000))
        else $error("unknown opcode result malformed");

    a_imm_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_IMM_REG) |->
        (mode_field == 2'd0 && rm_field == 3'd0 && displacement == 16'h0000))
        else $error("immediate-to-register carries memory fields");

    a_rm_reg_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_RM_REG) |-> (immediate == 16'h0000))
        else $error("register/memory move carries an immediate");

endmodule

`default_nettype wire

### test/x86_mov_byte_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// x86_mov_byte_stream_decoder_test
// Feeds the MOV decoder a byte stream of directed and random instructions,
// mixed with noise and cut-off instructions, under bursty input and a
// stalling receiver. A local decoder model predicts every result, and each
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_mov_byte_stream_decoder_test;

    import xmov_pkg::*;

    localparam int STREAM_BYTES = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic        direction;
    logic        wide;
    logic [1:0]  mode_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;

    logic [7:0]  code_stream[$];
    result_t     decoded_q[$];

    // decoder model state
    logic [2:0]  dec_pos;
    logic [7:0]  dec_op;
    logic [7:0]  dec_modrm;
    logic [15:0] dec_disp;
    logic [15:0] dec_imm;
    logic [2:0]  dec_len;

    logic        beat_taken;
    int          gap_left;
    int          burst_left;
    ready_mode_t ready_mode;
    int          ready_left;
    int          ready_tick;
    int          fail_count;
    int          cycle_count;

    x86_mov_byte_stream_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .direction    (direction),
        .wide         (wide),
        .mode_field   (mode_field),
        .reg_field    (reg_field),
        .rm_field     (rm_field),
        .displacement (displacement),
        .immediate    (immediate),
        .length       (length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic kind_t mov_form(input logic [7:0] b);
        kind_t f;
        casez (b)
            8'b1000_10??: f = KIND_RM_REG;
            8'b1100_011?: f = KIND_IMM_RM;
            8'b1011_????: f = KIND_IMM_REG;
            default:      f = KIND_UNKNOWN;
        endcase
        return f;
    endfunction

    function automatic int disp_count(input logic [7:0] modrm);
        int n;
        n = 0;
        if (modrm[7:6] == MOD_DISP8)
        begin
            n = 1;
        end
        else if (modrm[7:6] == MOD_DISP16)
        begin
            n = 2;
        end
        else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT)
        begin
            n = 2;
        end
        return n;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        kind_t   form;
        result_t r;
        int      idx;
        int      nd;
        logic    emit;
        emit = 1'b0;
        if (dec_pos == 3'd0)
        begin
            dec_op    = b;
            dec_modrm = 8'h00;
            dec_disp  = 16'h0000;
            dec_imm   = 16'h0000;
            form      = mov_form(b);
            if (form == KIND_UNKNOWN)
            begin
                dec_len = 3'd1;
                emit    = 1'b1;
            end
            else
            begin
                dec_len = (form == KIND_IMM_REG) ? 3'd2 + {2'b00, b[3]} : 3'd2;
                dec_pos = 3'd1;
            end
        end
        else
        begin
            form = mov_form(dec_op);
            if (form == KIND_IMM_REG)
            begin
                if (dec_pos == 3'd1)
                begin
                    dec_imm = {8'h00, b};
                end
                else
                begin
                    dec_imm[15:8] = dec_imm[15:8] | b;
                end
            end
            else if (dec_pos == 3'd1)
            begin
                dec_modrm = b;
                dec_len   = 3'(2 + disp_count(b));
                if (form == KIND_IMM_RM)
                begin
                    dec_len = dec_len + 3'd1 + {2'b00, dec_op[0]};
                end
            end
            else
            begin
                idx = int'(dec_pos) - 2;
                nd  = disp_count(dec_modrm);
                if (idx < nd)
                begin
                    dec_disp = dec_disp | ((idx % 2) ? {b, 8'h00} : {8'h00, b});
                end
                else
                begin
                    dec_imm = dec_imm | (((idx - nd) % 2) ? {b, 8'h00} : {8'h00, b});
                end
            end
            dec_pos = dec_pos + 3'd1;
            if (dec_pos >= dec_len)
            begin
                emit    = 1'b1;
                dec_pos = 3'd0;
            end
        end
        if (emit)
        begin
            r      = '0;
            r.kind = form;
            if (form == KIND_IMM_REG)
            begin
                r.wide      = dec_op[3];
                r.reg_field = dec_op[2:0];
            end
            else if (form != KIND_UNKNOWN)
            begin
                r.direction    = (form == KIND_RM_REG) ? dec_op[1] : 1'b0;
                r.wide         = dec_op[0];
                r.mode_field   = dec_modrm[7:6];
                r.reg_field    = dec_modrm[5:3];
                r.rm_field     = dec_modrm[2:0];
                r.displacement = dec_disp;
            end
            if (form != KIND_UNKNOWN)
            begin
                r.immediate = dec_imm;
            end
            r.length = dec_len;
            decoded_q.push_back(r);
        end
    endfunction

    function automatic logic [7:0] data_byte();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 7);
        b    = 8'($urandom_range(0, 255));
        if (pick == 0)
        begin
            b = 8'h00;
        end
        else if (pick == 1)
        begin
            b = 8'hFF;
        end
        return b;
    endfunction

    function automatic logic [7:0] modrm_byte();
        logic [2:0] rm;
        rm = ($urandom_range(0, 3) == 0) ? RM_DIRECT : 3'($urandom_range(0, 7));
        return {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rm};
    endfunction

    function automatic void add_random_mov();
        int unsigned pick;
        logic [7:0]  op;
        logic [7:0]  modrm;
        int          n_disp;
        int          n_imm;
        logic        cut;
        pick   = $urandom_range(0, 99);
        cut    = ($urandom_range(0, 19) == 0);
        n_disp = 0;
        n_imm  = 0;
        if (pick < 12)
        begin
            code_stream.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (pick < 48)
            begin
                op    = OP_RM_REG | 8'($urandom_range(0, 3));
                modrm = modrm_byte();
                code_stream.push_back(op);
                code_stream.push_back(modrm);
                n_disp = disp_count(modrm);
            end
            else if (pick < 74)
            begin
                op    = OP_IMM_RM | 8'($urandom_range(0, 1));
                modrm = modrm_byte();
                code_stream.push_back(op);
                code_stream.push_back(modrm);
                n_disp = disp_count(modrm);
                n_imm  = 1 + op[0];
            end
            else
            begin
                op = OP_IMM_REG | 8'($urandom_range(0, 15));
                code_stream.push_back(op);
                n_imm = 1 + op[3];
            end
            for (int i = 0; i < n_disp + n_imm; i++)
            begin
                code_stream.push_back(data_byte());
            end
            // drop the tail to leave a broken instruction
            if (cut)
            begin
                void'(code_stream.pop_back());
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    // stimulus and end of run
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        code_byte  = 8'h00;
        out_ready  = 1'b0;
        beat_taken = 1'b0;
        gap_left   = 0;
        burst_left = 0;
        ready_mode = READY_ALWAYS;
        ready_left = 0;
        ready_tick = 0;
        fail_count = 0;
        dec_pos    = 3'd0;
        dec_op     = 8'h00;
        dec_modrm  = 8'h00;
        dec_disp   = 16'h0000;
        dec_imm    = 16'h0000;
        dec_len    = 3'd0;

        code_stream = {8'hFF,
                       8'h8B, 8'h06, 8'h34, 8'h12,
                       8'h89, 8'h46, 8'h80,
                       8'hC7, 8'h86, 8'h01, 8'h80, 8'hFF, 8'h7F,
                       8'hC6, 8'hC0, 8'h55,
                       8'hB0, 8'h00,
                       8'hBF, 8'h34, 8'h12,
                       8'hA1,
                       8'h88, 8'hC0};
        while (code_stream.size() < STREAM_BYTES)
        begin
            add_random_mov();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (code_stream.size() != 0 || in_valid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (decoded_q.size() != 0)
        begin
            fail_count++;
            $display("%0d decoded instructions never came out", decoded_q.size());
        end

        if (fail_count == 0)
        begin
            $display("** x86_mov_byte_stream_decoder: PASSED **");
        end
        else
        begin
            $display("** x86_mov_byte_stream_decoder: FAILED **");
        end
        $finish;
    end

    // driver: bursts of bytes with random gaps
    always @(negedge clk)
    begin
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = in_valid;
        next_byte  = code_byte;
        if (rst_n && (!in_valid || beat_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (code_stream.size() > 0)
            begin
                next_valid = 1'b1;
                next_byte  = code_stream.pop_front();
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid  <= next_valid;
        code_byte <= next_byte;
    end

    // receiver: stall pattern switches among four randomly chosen modes
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 96);
        end
        else
        begin
            ready_left--;
        end
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: out_ready <= (ready_tick % 3) != 2;
            default:        out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        result_t want;
        beat_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            decode_byte(code_byte);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected result beat: kind %0d length %0d", kind, length);
                end
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("direction", 16'(want.direction), 16'(direction));
                check_field("wide", 16'(want.wide), 16'(wide));
                check_field("mode_field", 16'(want.mode_field), 16'(mode_field));
                check_field("reg_field", 16'(want.reg_field), 16'(reg_field));
                check_field("rm_field", 16'(want.rm_field), 16'(rm_field));
                check_field("displacement", want.displacement, displacement);
                check_field("immediate", want.immediate, immediate);
                check_field("length", 16'(want.length), 16'(length));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** x86_mov_byte_stream_decoder: FAILED **");
            $finish;
        end
    end

endmodule
